// ===== design/usrr_pkg.sv =====
// ----------------------------------------------------------------------------
// usrr_pkg
// Shared types, constants and descriptor ROM for the setup request responder.
// ----------------------------------------------------------------------------
package usrr_pkg;

	// Input beat: one decoded setup packet.
	typedef struct packed {
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] descriptor_select;
		logic [15:0] max_reply_length;
	} request_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_ACK   = 2'd1,
		KIND_STALL = 2'd2
	} kind_t;

	// Output beat: one reply result.
	typedef struct packed {
		kind_t      reply_kind;
		logic [7:0] reply_byte;
		logic       reply_last;
	} reply_t;

	typedef enum logic [2:0] {
		DESC_DEV,
		DESC_CFG,
		DESC_STR0,
		DESC_STR1,
		DESC_STR2
	} desc_t;

	localparam int LEN_W = 6;

	// Command handed from the classifier to the streamer.
	typedef struct packed {
		kind_t              op;
		desc_t              desc;
		logic [LEN_W-1:0]   len;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_SEND
	} bk_state_t;

	localparam int QUEUE_DEPTH = 2;

	// Request type field and standard request codes.
	localparam logic [1:0] TYPE_STANDARD = 2'd0;
	localparam logic [1:0] TYPE_RESERVED = 2'd3;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
	localparam logic [7:0] REQ_SET_INTERFACE = 8'd11;
	localparam logic [7:0] DT_DEVICE = 8'd1;
	localparam logic [7:0] DT_CONFIG = 8'd2;
	localparam logic [7:0] DT_STRING = 8'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_RELEASE = 2'd2;

	localparam logic [15:0] VENDOR_ID_RESET = 16'h045E;
	localparam logic [15:0] PRODUCT_ID_RESET = 16'h028E;
	localparam logic [15:0] DEVICE_RELEASE_RESET = 16'h0114;

	localparam int DEV_LEN = 18;
	localparam int CFG_LEN = 32;
	localparam int LANG_LEN = 4;
	localparam int MFR_CHARS_N = 22;
	localparam int PROD_CHARS_N = 10;
	localparam int MFR_LEN = 2 + 2 * MFR_CHARS_N;
	localparam int PROD_LEN = 2 + 2 * PROD_CHARS_N;

	// Bytes 8 to 13 are filled from the id registers.
	localparam logic [7:0] DEV_HEAD [DEV_LEN] = '{
		8'd18, 8'd1, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'd8,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd1, 8'd2, 8'd0, 8'd1
	};

	localparam logic [7:0] CFG_ROM [CFG_LEN] = '{
		8'd9, 8'd2, 8'd32, 8'd0, 8'd1, 8'd1, 8'd0, 8'hC0, 8'd250,
		8'd9, 8'd4, 8'd0, 8'd0, 8'd2, 8'hFF, 8'h5D, 8'h01, 8'd0,
		8'd7, 8'd5, 8'h81, 8'h03, 8'd32, 8'd0, 8'd4,
		8'd7, 8'd5, 8'h01, 8'h03, 8'd32, 8'd0, 8'd8
	};

	localparam logic [7:0] LANG_ROM [LANG_LEN] = '{8'd4, 8'd3, 8'h09, 8'h04};

	localparam logic [7:0] MFR_CHARS [MFR_CHARS_N] = '{
		8'hA9, 8'h4D, 8'h69, 8'h63, 8'h72, 8'h6F, 8'h73, 8'h6F, 8'h66, 8'h74, 8'h20,
		8'h43, 8'h6F, 8'h72, 8'h70, 8'h6F, 8'h72, 8'h61, 8'h74, 8'h69, 8'h6F, 8'h6E
	};

	localparam logic [7:0] PROD_CHARS [PROD_CHARS_N] = '{
		8'h43, 8'h6F, 8'h6E, 8'h74, 8'h72, 8'h6F, 8'h6C, 8'h6C, 8'h65, 8'h72
	};

	function automatic logic [LEN_W-1:0] desc_len(desc_t d);
		logic [LEN_W-1:0] n;
		case (d)
			DESC_DEV:  n = LEN_W'(DEV_LEN);
			DESC_CFG:  n = LEN_W'(CFG_LEN);
			DESC_STR0: n = LEN_W'(LANG_LEN);
			DESC_STR1: n = LEN_W'(MFR_LEN);
			DESC_STR2: n = LEN_W'(PROD_LEN);
			default:   n = '0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] desc_byte(desc_t d, logic [LEN_W-1:0] idx,
			logic [15:0] vid, logic [15:0] pid, logic [15:0] rel);
		logic [7:0] b;
		logic [4:0] ch;
		b = '0;
		// String bodies are UTF-16LE: even offsets carry a character, odd ones zero.
		ch = 5'((idx - LEN_W'(2)) >> 1);
		case (d)
			DESC_DEV: begin
				case (idx)
					6'd8:    b = vid[7:0];
					6'd9:    b = vid[15:8];
					6'd10:   b = pid[7:0];
					6'd11:   b = pid[15:8];
					6'd12:   b = rel[7:0];
					6'd13:   b = rel[15:8];
					default: if (idx < LEN_W'(DEV_LEN)) b = DEV_HEAD[idx[4:0]];
				endcase
			end
			DESC_CFG: b = CFG_ROM[idx[4:0]];
			DESC_STR0: b = LANG_ROM[idx[1:0]];
			DESC_STR1: begin
				if (idx == '0) b = 8'(MFR_LEN);
				else if (idx == LEN_W'(1)) b = DT_STRING;
				else if (!idx[0] && ch < 5'(MFR_CHARS_N)) b = MFR_CHARS[ch];
			end
			DESC_STR2: begin
				if (idx == '0) b = 8'(PROD_LEN);
				else if (idx == LEN_W'(1)) b = DT_STRING;
				else if (!idx[0] && ch < 5'(PROD_CHARS_N)) b = PROD_CHARS[ch[3:0]];
			end
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

// ===== design/usrr_front.sv =====
// ----------------------------------------------------------------------------
// usrr_front
// Decodes a setup packet into a reply command: stall, acknowledge, or a
// descriptor stream with its length already cut to the host's limit.
// ----------------------------------------------------------------------------
module usrr_front (
	input  logic               start,
	input  logic               full,
	input  usrr_pkg::request_t request,
	output logic               busy,
	output logic               push,
	output usrr_pkg::cmd_t     cmd
);

	logic [1:0]                 rtype;
	logic [7:0]                 dtype;
	logic [7:0]                 didx;
	logic                       stall;
	logic                       has_desc;
	usrr_pkg::desc_t            desc;
	logic [usrr_pkg::LEN_W-1:0] dlen;
	logic [usrr_pkg::LEN_W-1:0] len;

	assign busy = full;
	assign push = start && !full;

	assign rtype = request.request_type[6:5];
	assign dtype = request.descriptor_select[15:8];
	assign didx = request.descriptor_select[7:0];

	always_comb begin
		stall = 1'b0;
		has_desc = 1'b0;
		desc = usrr_pkg::DESC_DEV;
		if (rtype == usrr_pkg::TYPE_RESERVED) begin
			stall = 1'b1;
		end else if (rtype == usrr_pkg::TYPE_STANDARD) begin
			case (request.request_code) inside
				usrr_pkg::REQ_GET_DESCRIPTOR: begin
					has_desc = 1'b1;
					case (dtype)
						usrr_pkg::DT_DEVICE: desc = usrr_pkg::DESC_DEV;
						usrr_pkg::DT_CONFIG: desc = usrr_pkg::DESC_CFG;
						usrr_pkg::DT_STRING: begin
							case (didx)
								8'd0:    desc = usrr_pkg::DESC_STR0;
								8'd1:    desc = usrr_pkg::DESC_STR1;
								8'd2:    desc = usrr_pkg::DESC_STR2;
								default: stall = 1'b1;
							endcase
						end
						default: stall = 1'b1;
					endcase
				end
				usrr_pkg::REQ_SET_CONFIGURATION, usrr_pkg::REQ_SET_INTERFACE: ;
				default: stall = 1'b1;
			endcase
		end
	end

	assign dlen = has_desc ? usrr_pkg::desc_len(desc) : '0;

	always_comb begin
		if (request.max_reply_length < 16'(dlen)) begin
			len = request.max_reply_length[usrr_pkg::LEN_W-1:0];
		end else begin
			len = dlen;
		end
	end

	always_comb begin
		cmd.desc = desc;
		cmd.len = len;
		if (stall) begin
			cmd.op = usrr_pkg::KIND_STALL;
		end else if (!request.request_type[7] || len == '0) begin
			cmd.op = usrr_pkg::KIND_ACK;
		end else begin
			cmd.op = usrr_pkg::KIND_DATA;
		end
	end

endmodule

// ===== design/usrr_queue.sv =====
// ----------------------------------------------------------------------------
// usrr_queue
// Small command FIFO between the decoder and the reply streamer.
// ----------------------------------------------------------------------------
module usrr_queue #(
	parameter int DEPTH = usrr_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  usrr_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output usrr_pkg::cmd_t rd_cmd,
	output logic           empty,
	output logic           full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	usrr_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == CNT_W'(DEPTH));
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("command queue underflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("command queue count out of range");

endmodule

// ===== design/usrr_back.sv =====
// ----------------------------------------------------------------------------
// usrr_back
// Reply streamer: takes commands from the queue and sends one result beat
// per cycle, reading descriptor bytes from the ROM and the id registers.
// ----------------------------------------------------------------------------
module usrr_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [usrr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                       cfg_data,
	input  logic                              empty,
	input  usrr_pkg::cmd_t                    rd_cmd,
	output logic                              pop,
	output logic                              reply_valid,
	output usrr_pkg::reply_t                  reply
);

	usrr_pkg::bk_state_t        state_q;
	usrr_pkg::bk_state_t        state_d;
	usrr_pkg::cmd_t             cmd_q;
	logic [usrr_pkg::LEN_W-1:0] idx_q;
	logic [15:0]                vendor_id_q;
	logic [15:0]                product_id_q;
	logic [15:0]                device_release_q;
	logic                       beat_valid;
	usrr_pkg::reply_t           beat;
	logic                       load;
	logic                       reply_valid_q;
	usrr_pkg::reply_t           reply_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_id_q <= usrr_pkg::VENDOR_ID_RESET;
			product_id_q <= usrr_pkg::PRODUCT_ID_RESET;
			device_release_q <= usrr_pkg::DEVICE_RELEASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				usrr_pkg::CFG_VENDOR_ID:      vendor_id_q <= cfg_data;
				usrr_pkg::CFG_PRODUCT_ID:     product_id_q <= cfg_data;
				usrr_pkg::CFG_DEVICE_RELEASE: device_release_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		beat_valid = 1'b0;
		load = 1'b0;
		beat.reply_kind = cmd_q.op;
		beat.reply_byte = '0;
		beat.reply_last = 1'b1;
		case (state_q)
			usrr_pkg::BK_IDLE: begin
				if (!empty) begin
					load = 1'b1;
					state_d = usrr_pkg::BK_SEND;
				end
			end
			usrr_pkg::BK_SEND: begin
				beat_valid = 1'b1;
				if (cmd_q.op == usrr_pkg::KIND_DATA) begin
					beat.reply_byte = usrr_pkg::desc_byte(cmd_q.desc, idx_q,
						vendor_id_q, product_id_q, device_release_q);
					beat.reply_last = (idx_q == cmd_q.len - 1'b1);
				end
				// Chain straight into the next queued command after the final beat.
				if (beat.reply_last) begin
					if (!empty) begin
						load = 1'b1;
					end else begin
						state_d = usrr_pkg::BK_IDLE;
					end
				end
			end
			default: state_d = usrr_pkg::BK_IDLE;
		endcase
	end

	assign pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= usrr_pkg::BK_IDLE;
			reply_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			reply_valid_q <= beat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= rd_cmd;
			idx_q <= '0;
		end else if (beat_valid) begin
			idx_q <= idx_q + 1'b1;
		end
		reply_q <= beat;
	end

	assign reply_valid = reply_valid_q;
	assign reply = reply_q;

	a_nondata_last: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && reply.reply_kind != usrr_pkg::KIND_DATA |-> reply.reply_last)
		else $error("acknowledge or stall beat without last marker");

	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && reply.reply_kind != usrr_pkg::KIND_DATA |-> reply.reply_byte == '0)
		else $error("acknowledge or stall beat with nonzero byte");

	a_valid_from_send: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid |-> $past(state_q) == usrr_pkg::BK_SEND)
		else $error("reply beat without streaming state");

endmodule

// ===== design/usb_setup_request_responder.sv =====
// ----------------------------------------------------------------------------
// usb_setup_request_responder
// Answers decoded USB setup packets from a fixed descriptor ROM.
//
// Input: drive request and raise start; the packet is taken at a clock edge
// where start is high and busy is low. busy rises only when the command
// queue between the decoder and the streamer is full.
// Output: each result beat is on reply for exactly one cycle while
// reply_valid is high; the receiver cannot hold beats off. A packet gives
// either one acknowledge or stall beat, or 1 to 46 data beats (one per
// cycle, the final one with reply_last set).
// Path: when the streamer is idle, a taken packet passes through the queue,
// the streamer's command register and the output register before its first
// beat appears. Throughput is set by the streamer, one beat per cycle, and
// queued packets follow without a gap.
// Configuration: cfg_we writes cfg_data into vendor_id, product_id or
// device_release (indexes 0 to 2) at once; write only while no reply is
// pending. Reset clears the queue and streamer and restores default ids.
// ----------------------------------------------------------------------------
module usb_setup_request_responder #(
	parameter int QUEUE_DEPTH = usrr_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  usrr_pkg::request_t             request,
	output logic                           busy,
	output logic                           reply_valid,
	output usrr_pkg::reply_t               reply,
	input  logic                           cfg_we,
	input  logic [usrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);

	logic           push;
	logic           pop;
	logic           empty;
	logic           full;
	usrr_pkg::cmd_t wr_cmd;
	usrr_pkg::cmd_t rd_cmd;

	usrr_front u_front (
		.start   (start),
		.full    (full),
		.request (request),
		.busy    (busy),
		.push    (push),
		.cmd     (wr_cmd)
	);

	usrr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.empty  (empty),
		.full   (full)
	);

	usrr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.empty       (empty),
		.rd_cmd      (rd_cmd),
		.pop         (pop),
		.reply_valid (reply_valid),
		.reply       (reply)
	);

endmodule
